### rtl/sgr_pkg.sv
package sgr_pkg;

    localparam int MAX_GROUP = 16;
    localparam int DATA_W    = 32;
    localparam int CFG_W     = 5;
    // buffer address and fill count widths
    localparam int ADDR_W    = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;
    localparam int CNT_W     = $clog2(MAX_GROUP + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_LOAD
    } sgr_state_t;

    // controller -> datapath
    typedef struct packed {
        logic accept;
        logic rd;
        logic load;
    } sgr_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic emit_need;
        logic out_free;
        logic last_idx;
    } sgr_sts_t;

endpackage

### rtl/sgr_ifs.sv
interface sgr_in_if;
    import sgr_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] value_in;
    logic                     list_last;

    modport source (output valid, output value_in, output list_last, input ready);
    modport sink   (input valid, input value_in, input list_last, output ready);
endinterface

interface sgr_out_if;
    import sgr_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] value_out;
    logic                     run_end;
    logic                     list_end;

    modport source (output valid, output value_out, output run_end, output list_end,
                    input ready);
    modport sink   (input valid, input value_out, input run_end, input list_end,
                    output ready);
endinterface

### rtl/sgr_ctrl.sv
module sgr_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  sgr_pkg::sgr_sts_t sts,
    output sgr_pkg::sgr_cmd_t cmd
);
    import sgr_pkg::*;

    sgr_state_t state_reg;
    sgr_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    if (sts.emit_need)
                    begin
                        state_next = ST_READ;
                    end
                end
            end
            ST_READ:
            begin
                cmd.rd     = 1'b1;
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                if (sts.out_free)
                begin
                    cmd.load   = 1'b1;
                    state_next = sts.last_idx ? ST_IDLE : ST_READ;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // a read is always followed by a load attempt
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READ) |=> (state_reg == ST_LOAD))
        else $error("read not followed by load");

    // last load of a run returns to idle
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load && sts.last_idx) |=> (state_reg == ST_IDLE))
        else $error("run end did not return to idle");

    // stalled output holds the controller in load
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LOAD && !sts.out_free) |=> (state_reg == ST_LOAD))
        else $error("left load while output busy");

endmodule

### rtl/sgr_datapath.sv
module sgr_datapath
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [sgr_pkg::CFG_W-1:0]        cfg_data,
    input  logic signed [sgr_pkg::DATA_W-1:0] value_in,
    input  logic                             list_last,
    output logic signed [sgr_pkg::DATA_W-1:0] value_out,
    output logic                             run_end,
    output logic                             list_end,
    output logic                             out_valid,
    input  logic                             out_ready,
    input  sgr_pkg::sgr_cmd_t                cmd,
    output sgr_pkg::sgr_sts_t                sts
);
    import sgr_pkg::*;

    logic [CFG_W-1:0]  group_size_reg;
    logic [CNT_W-1:0]  fill_count_reg;
    logic [CNT_W-1:0]  fill_count_next;
    logic [CNT_W-1:0]  n_reg;
    logic [CNT_W-1:0]  idx_reg;
    logic              fwd_reg;
    logic              last_reg;
    logic              out_valid_reg;

    logic [DATA_W-1:0] mem [MAX_GROUP];
    logic [DATA_W-1:0] rd_data_reg;
    logic signed [DATA_W-1:0] value_out_reg;
    logic              run_end_reg;
    logic              list_end_reg;

    logic [CNT_W-1:0]  eff_k;
    logic [CNT_W-1:0]  n_new;
    logic              full_group;
    logic [CNT_W-1:0]  rd_idx;
    logic              fin;

    // group size zero acts as one, above MAX_GROUP saturates
    always_comb
    begin
        if (group_size_reg == '0)
        begin
            eff_k = CNT_W'(1);
        end
        else if (32'(group_size_reg) > 32'(MAX_GROUP))
        begin
            eff_k = CNT_W'(MAX_GROUP);
        end
        else
        begin
            eff_k = CNT_W'(group_size_reg);
        end
    end

    assign n_new      = fill_count_reg + CNT_W'(1);
    assign full_group = (n_new >= eff_k);
    assign rd_idx     = fwd_reg ? idx_reg : (n_reg - CNT_W'(1) - idx_reg);
    assign fin        = (idx_reg == n_reg - CNT_W'(1));

    assign fill_count_next = full_group || list_last ? '0 : n_new;

    assign sts.emit_need = full_group || list_last;
    assign sts.out_free  = !out_valid_reg || out_ready;
    assign sts.last_idx  = fin;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            group_size_reg <= CFG_W'(1);
            fill_count_reg <= '0;
            n_reg          <= '0;
            idx_reg        <= '0;
            fwd_reg        <= 1'b0;
            last_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                group_size_reg <= cfg_data;
            end
            if (cmd.accept)
            begin
                fill_count_reg <= fill_count_next;
                n_reg          <= n_new;
                idx_reg        <= '0;
                fwd_reg        <= !full_group;
                last_reg       <= list_last;
            end
            else if (cmd.load)
            begin
                idx_reg <= idx_reg + CNT_W'(1);
            end
            if (cmd.load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // group buffer: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            mem[fill_count_reg[ADDR_W-1:0]] <= value_in;
        end
        if (cmd.rd)
        begin
            rd_data_reg <= mem[rd_idx[ADDR_W-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            value_out_reg <= rd_data_reg;
            run_end_reg   <= fin;
            list_end_reg  <= fin && last_reg;
        end
    end

    assign value_out = value_out_reg;
    assign run_end   = run_end_reg;
    assign list_end  = list_end_reg;
    assign out_valid = out_valid_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        fill_count_reg < CNT_W'(MAX_GROUP))
        else $error("fill count out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> (idx_reg < n_reg))
        else $error("load past end of run");

    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.accept && sts.emit_need) |=> (fill_count_reg == '0))
        else $error("buffer not emptied after run");

endmodule

### rtl/stream_group_reverser_top.sv
// An item that completes a run is written to the group buffer; each result is then
//   read from it (read state) and moved to the output register (load state), waiting
//   while the output is full. An item that causes no result leaves the input ready;
//   one that ends a run of n values holds it until all n are loaded, one read at a time.
// Reset (rst_n, async, active low): group size 1, buffer empty, output empty.
//   Buffer contents are not cleared; only entries written for the current group are read.
module stream_group_reverser_top
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [sgr_pkg::CFG_W-1:0] cfg_data,
    sgr_in_if.sink                    in_ch,
    sgr_out_if.source                 out_ch
);
    import sgr_pkg::*;

    // command/status bundle between controller and datapath
    sgr_cmd_t cmd;
    sgr_sts_t sts;

    // Controller: idle takes an item (writes it into the buffer), then walks
    // read -> load per result until the run is out. The input is only ready
    // in idle, but the output register lets a final result wait while the
    // next item is already taken.
    sgr_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Datapath: group size register, fill count, 16-entry buffer, run index
    // (reversed for a full group, arrival order for a partial list end) and
    // the output register.
    sgr_datapath u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .value_in  (in_ch.value_in),
        .list_last (in_ch.list_last),
        .value_out (out_ch.value_out),
        .run_end   (out_ch.run_end),
        .list_end  (out_ch.list_end),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule
